// ===== rtl/least_loaded_host_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// least loaded host allocator assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_HOST_ALLOCATOR_UNIT_ASSERT_SVH
`define LEAST_LOADED_HOST_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LLHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/llha_pkg.sv =====
// ----------------------------------------------------------------------------
// llha_pkg
// shared widths, codes and types of the least loaded host allocator
// ----------------------------------------------------------------------------
package llha_pkg;

  localparam int MAX_HOSTS = 64;
  localparam int POS_W     = $clog2(MAX_HOSTS + 1);
  localparam int ADDR_W    = $clog2(MAX_HOSTS);

  localparam int ID_W     = 16;
  localparam int LOAD_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int JOB_W    = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [POS_W-1:0]  HOST_LIMIT = POS_W'(MAX_HOSTS);
  localparam logic [LOAD_W-1:0] CAP_RESET  = LOAD_W'(100);

  // register word index within the configuration space
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_NOHOST = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_BLD_RD   = 8'b0000_0010,
    ST_BLD_MV   = 8'b0000_0100,
    ST_ROOT_RD  = 8'b0000_1000,
    ST_ROOT_CHK = 8'b0001_0000,
    ST_SIFT     = 8'b0010_0000,
    ST_WR_MV    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LOAD_W-1:0] load;
  } host_t;

endpackage

// ===== rtl/least_loaded_host_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// least loaded host allocator unit; clear, load, unused code: no heap walk
// allocate: no host if empty, else root read and check; reject or one host ends
// there, else raised root sifts down <= log2 n levels; first allocate after a load
// builds the heap; one item at a time; sync reset empties table, capacity 100
// ----------------------------------------------------------------------------
`include "least_loaded_host_allocator_unit_assert.svh"

module least_loaded_host_allocator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [llha_pkg::FUNC_W-1:0]         in_func,
  input  logic [llha_pkg::ID_W-1:0]           in_host_id,
  input  logic [llha_pkg::LOAD_W-1:0]         in_host_load,
  input  logic [llha_pkg::LOAD_W-1:0]         in_job_load,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [llha_pkg::STATUS_W-1:0]       out_status,
  output logic [llha_pkg::ID_W-1:0]           out_placed_host,
  output logic [llha_pkg::LOAD_W-1:0]         out_prev_load,
  output logic [llha_pkg::LOAD_W-1:0]         out_new_load,
  output logic [llha_pkg::JOB_W-1:0]          out_job_number,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [llha_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [llha_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [llha_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int POS_W  = llha_pkg::POS_W;
  localparam int ADDR_W = llha_pkg::ADDR_W;

  llha_pkg::state_t            state_r, state_nxt;
  logic [POS_W-1:0]            host_count_r, host_count_nxt;
  logic                        heap_ready_r, heap_ready_nxt;
  logic [llha_pkg::JOB_W-1:0]  job_cnt_r, job_cnt_nxt;
  logic [llha_pkg::LOAD_W-1:0] cap_r, cap_nxt;
  logic                        bld_r, bld_nxt;
  logic [POS_W-1:0]            p_r, p_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  llha_pkg::host_t             mv_r, mv_nxt;
  logic [llha_pkg::LOAD_W-1:0] job_r, job_nxt;

  llha_pkg::status_t           res_status_r, res_status_nxt;
  logic [llha_pkg::ID_W-1:0]   res_host_r, res_host_nxt;
  logic [llha_pkg::LOAD_W-1:0] res_prev_r, res_prev_nxt;
  logic [llha_pkg::LOAD_W-1:0] res_new_r, res_new_nxt;
  logic [llha_pkg::JOB_W-1:0]  res_job_r, res_job_nxt;

  logic                        out_valid_r, out_valid_nxt;
  llha_pkg::status_t           out_status_r, out_status_nxt;
  logic [llha_pkg::ID_W-1:0]   out_host_r, out_host_nxt;
  logic [llha_pkg::LOAD_W-1:0] out_prev_r, out_prev_nxt;
  logic [llha_pkg::LOAD_W-1:0] out_new_r, out_new_nxt;
  logic [llha_pkg::JOB_W-1:0]  out_job_r, out_job_nxt;

  // host table, heap positions 1..n live at index position-1
  llha_pkg::host_t             host_mem [llha_pkg::MAX_HOSTS];
  llha_pkg::host_t             rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]           rd_a_addr, rd_b_addr;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  llha_pkg::host_t             mem_wdata;

  logic                        in_accept;
  logic                        cfg_wr;
  logic [POS_W-1:0]            half_n;
  logic [POS_W:0]              c_cur;
  logic [POS_W:0]              ch;
  logic [POS_W-1:0]            ch_pos;
  logic                        sel_right;
  llha_pkg::host_t             chd;
  logic                        stop;
  logic [llha_pkg::LOAD_W:0]   sum;
  logic                        fits;
  logic                        sift_done;

  function automatic logic [ADDR_W-1:0] pos_idx(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] t;
    t = p - 1'b1;
    return t[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] left_idx(input logic [POS_W-1:0] p);
    logic [POS_W:0] t;
    t = {p, 1'b0} - 1'b1;
    return t[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] right_idx(input logic [POS_W-1:0] p);
    logic [POS_W:0] t;
    t = {p, 1'b0};
    return t[ADDR_W-1:0];
  endfunction

  assign in_stall  = (state_r != llha_pkg::ST_IDLE) || !rst_n;
  assign in_accept = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_placed_host = out_host_r;
  assign out_prev_load   = out_prev_r;
  assign out_new_load    = out_new_r;
  assign out_job_number  = out_job_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[llha_pkg::CFG_ADDR_W-1] == llha_pkg::REG_CAPACITY) ?
                  llha_pkg::CFG_DATA_W'(cap_r) : '0;

  // shared compare unit: smaller child, then moving entry against it
  assign half_n    = host_count_r >> 1;
  assign c_cur     = {pos_r, 1'b0};
  assign sel_right = (c_cur < {1'b0, host_count_r}) && (rd_b_r.load < rd_a_r.load);
  assign ch        = sel_right ? c_cur + 1'b1 : c_cur;
  assign ch_pos    = ch[POS_W-1:0];
  assign chd       = sel_right ? rd_b_r : rd_a_r;
  assign stop      = mv_r.load < chd.load;
  assign sum       = {1'b0, rd_a_r.load} + {1'b0, job_r};
  assign fits      = sum <= {1'b0, cap_r};

  always_comb begin
    state_nxt      = state_r;
    host_count_nxt = host_count_r;
    heap_ready_nxt = heap_ready_r;
    job_cnt_nxt    = job_cnt_r;
    cap_nxt        = cap_r;
    bld_nxt        = bld_r;
    p_nxt          = p_r;
    pos_nxt        = pos_r;
    mv_nxt         = mv_r;
    job_nxt        = job_r;
    res_status_nxt = res_status_r;
    res_host_nxt   = res_host_r;
    res_prev_nxt   = res_prev_r;
    res_new_nxt    = res_new_r;
    res_job_nxt    = res_job_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_host_nxt   = out_host_r;
    out_prev_nxt   = out_prev_r;
    out_new_nxt    = out_new_r;
    out_job_nxt    = out_job_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_idx(pos_r);
    mem_wdata      = mv_r;
    rd_a_addr      = left_idx(pos_r);
    rd_b_addr      = right_idx(pos_r);
    sift_done      = 1'b0;

    if (cfg_wr && (paddr[llha_pkg::CFG_ADDR_W-1] == llha_pkg::REG_CAPACITY)) begin
      cap_nxt = pwdata[llha_pkg::LOAD_W-1:0];
    end

    unique case (state_r)
      llha_pkg::ST_IDLE: begin
        if (in_accept) begin
          job_nxt        = in_job_load;
          res_status_nxt = llha_pkg::STAT_DONE;
          res_host_nxt   = '0;
          res_prev_nxt   = '0;
          res_new_nxt    = '0;
          res_job_nxt    = '0;
          state_nxt      = llha_pkg::ST_DONE;
          case (in_func)
            llha_pkg::FUNC_CLEAR: begin
              host_count_nxt = '0;
              heap_ready_nxt = 1'b0;
              job_cnt_nxt    = '0;
            end
            llha_pkg::FUNC_LOAD: begin
              if (host_count_r >= llha_pkg::HOST_LIMIT) begin
                res_status_nxt = llha_pkg::STAT_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = host_count_r[ADDR_W-1:0];
                mem_wdata      = '{id: in_host_id, load: in_host_load};
                host_count_nxt = host_count_r + 1'b1;
                heap_ready_nxt = 1'b0;
              end
            end
            llha_pkg::FUNC_ALLOC: begin
              job_cnt_nxt = job_cnt_r + 1'b1;
              res_job_nxt = job_cnt_r + 1'b1;
              if (host_count_r == '0) begin
                res_status_nxt = llha_pkg::STAT_NOHOST;
              end else if (heap_ready_r || (half_n == '0)) begin
                heap_ready_nxt = 1'b1;
                state_nxt      = llha_pkg::ST_ROOT_RD;
              end else begin
                p_nxt     = half_n;
                bld_nxt   = 1'b1;
                state_nxt = llha_pkg::ST_BLD_RD;
              end
            end
            default: begin
              state_nxt = llha_pkg::ST_DONE;
            end
          endcase
        end
      end

      llha_pkg::ST_BLD_RD: begin
        rd_a_addr = pos_idx(p_r);
        state_nxt = llha_pkg::ST_BLD_MV;
      end

      // interior node always has a left child
      llha_pkg::ST_BLD_MV: begin
        mv_nxt    = rd_a_r;
        pos_nxt   = p_r;
        rd_a_addr = left_idx(p_r);
        rd_b_addr = right_idx(p_r);
        state_nxt = llha_pkg::ST_SIFT;
      end

      llha_pkg::ST_ROOT_RD: begin
        rd_a_addr = '0;
        state_nxt = llha_pkg::ST_ROOT_CHK;
      end

      llha_pkg::ST_ROOT_CHK: begin
        if (fits) begin
          res_host_nxt = rd_a_r.id;
          res_prev_nxt = rd_a_r.load;
          res_new_nxt  = sum[llha_pkg::LOAD_W-1:0];
          mv_nxt       = '{id: rd_a_r.id, load: sum[llha_pkg::LOAD_W-1:0]};
          pos_nxt      = POS_W'(1);
          if (half_n == '0) begin
            // single host: raised root written back in place
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{id: rd_a_r.id, load: sum[llha_pkg::LOAD_W-1:0]};
            state_nxt = llha_pkg::ST_DONE;
          end else begin
            rd_a_addr = left_idx(POS_W'(1));
            rd_b_addr = right_idx(POS_W'(1));
            state_nxt = llha_pkg::ST_SIFT;
          end
        end else begin
          res_status_nxt = llha_pkg::STAT_REJECT;
          state_nxt      = llha_pkg::ST_DONE;
        end
      end

      llha_pkg::ST_SIFT: begin
        mem_we = 1'b1;
        if (stop) begin
          sift_done = 1'b1;
        end else begin
          mem_wdata = chd;
          pos_nxt   = ch_pos;
          if (ch_pos <= half_n) begin
            rd_a_addr = left_idx(ch_pos);
            rd_b_addr = right_idx(ch_pos);
          end else begin
            state_nxt = llha_pkg::ST_WR_MV;
          end
        end
      end

      llha_pkg::ST_WR_MV: begin
        mem_we    = 1'b1;
        sift_done = 1'b1;
      end

      llha_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_host_nxt   = res_host_r;
          out_prev_nxt   = res_prev_r;
          out_new_nxt    = res_new_r;
          out_job_nxt    = res_job_r;
          state_nxt      = llha_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = llha_pkg::ST_IDLE;
      end
    endcase

    // end of one sift: next build node, root check, or result
    if (sift_done) begin
      if (bld_r) begin
        if (p_r == POS_W'(1)) begin
          bld_nxt        = 1'b0;
          heap_ready_nxt = 1'b1;
          state_nxt      = llha_pkg::ST_ROOT_RD;
        end else begin
          p_nxt     = p_r - 1'b1;
          state_nxt = llha_pkg::ST_BLD_RD;
        end
      end else begin
        state_nxt = llha_pkg::ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      host_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= host_mem[rd_a_addr];
    rd_b_r <= host_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= llha_pkg::ST_IDLE;
      host_count_r <= '0;
      heap_ready_r <= 1'b0;
      job_cnt_r    <= '0;
      cap_r        <= llha_pkg::CAP_RESET;
      bld_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      host_count_r <= host_count_nxt;
      heap_ready_r <= heap_ready_nxt;
      job_cnt_r    <= job_cnt_nxt;
      cap_r        <= cap_nxt;
      bld_r        <= bld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    pos_r        <= pos_nxt;
    mv_r         <= mv_nxt;
    job_r        <= job_nxt;
    res_status_r <= res_status_nxt;
    res_host_r   <= res_host_nxt;
    res_prev_r   <= res_prev_nxt;
    res_new_r    <= res_new_nxt;
    res_job_r    <= res_job_nxt;
    out_status_r <= out_status_nxt;
    out_host_r   <= out_host_nxt;
    out_prev_r   <= out_prev_nxt;
    out_new_r    <= out_new_nxt;
    out_job_r    <= out_job_nxt;
  end

  `LLHA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != llha_pkg::ST_IDLE, "item accepted but sequencer stayed idle")
  `LLHA_ASSERT_IMP(a_count_bound, 1'b1, host_count_r <= llha_pkg::HOST_LIMIT, "host count above table size")
  `LLHA_ASSERT_IMP(a_wr_in_table, mem_we && (state_r != llha_pkg::ST_IDLE), {1'b0, mem_waddr} < host_count_r, "heap write outside loaded hosts")
  `LLHA_ASSERT_IMP(a_build_pending, bld_r, !heap_ready_r, "heap marked ready during build")
  `LLHA_ASSERT_IMP(a_sift_pos, state_r == llha_pkg::ST_SIFT, (pos_r != '0) && (pos_r <= half_n), "sift position has no child")

endmodule

// ===== verif/llha_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least loaded host allocator checker
// watches the item, result and register ports, keeps its own host heap and
// compares every result item field by field against the predicted report
// ----------------------------------------------------------------------------
module llha_alloc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [llha_pkg::FUNC_W-1:0] in_func,
  input  logic [llha_pkg::ID_W-1:0]   in_host_id,
  input  logic [llha_pkg::LOAD_W-1:0] in_host_load,
  input  logic [llha_pkg::LOAD_W-1:0] in_job_load,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [llha_pkg::STATUS_W-1:0] out_status,
  input  logic [llha_pkg::ID_W-1:0]   out_placed_host,
  input  logic [llha_pkg::LOAD_W-1:0] out_prev_load,
  input  logic [llha_pkg::LOAD_W-1:0] out_new_load,
  input  logic [llha_pkg::JOB_W-1:0]  out_job_number,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llha_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [llha_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          outstanding,
  output int                          errors
);

  localparam logic [llha_pkg::CFG_ADDR_W-1:0] CAP_ADDR = {llha_pkg::REG_CAPACITY, 2'b00};

  typedef struct packed {
    llha_pkg::status_t           status;
    logic [llha_pkg::ID_W-1:0]   host;
    logic [llha_pkg::LOAD_W-1:0] prev_load;
    logic [llha_pkg::LOAD_W-1:0] new_load;
    logic [llha_pkg::JOB_W-1:0]  job_number;
  } alloc_report_t;

  logic [llha_pkg::LOAD_W-1:0] load_mem [1:llha_pkg::MAX_HOSTS];
  logic [llha_pkg::ID_W-1:0]   id_mem   [1:llha_pkg::MAX_HOSTS];
  int                          host_total;
  bit                          heap_built;
  logic [llha_pkg::JOB_W-1:0]  alloc_seq;
  logic [llha_pkg::LOAD_W-1:0] cap_reg;

  alloc_report_t report_q[$];
  alloc_report_t want;

  initial begin
    outstanding = 0;
    errors      = 0;
  end

  // equal loads let the moving host sink further
  function automatic void sink_host(int pos, int n);
    logic [llha_pkg::LOAD_W-1:0] mv_load;
    logic [llha_pkg::ID_W-1:0]   mv_id;
    int                          c;
    mv_load = load_mem[pos];
    mv_id   = id_mem[pos];
    c       = 2 * pos;
    while (c <= n) begin
      if (c < n && load_mem[c+1] < load_mem[c]) c = c + 1;
      if (mv_load < load_mem[c]) break;
      load_mem[c/2] = load_mem[c];
      id_mem[c/2]   = id_mem[c];
      c = 2 * c;
    end
    load_mem[c/2] = mv_load;
    id_mem[c/2]   = mv_id;
  endfunction

  function automatic alloc_report_t compute_report(logic [llha_pkg::FUNC_W-1:0] func,
      logic [llha_pkg::ID_W-1:0] hid, logic [llha_pkg::LOAD_W-1:0] hload,
      logic [llha_pkg::LOAD_W-1:0] job);
    alloc_report_t rep;
    int            sum;
    rep = '0;
    rep.status = llha_pkg::STAT_DONE;
    case (func)
      llha_pkg::FUNC_CLEAR: begin
        host_total = 0;
        heap_built = 1'b0;
        alloc_seq  = '0;
      end
      llha_pkg::FUNC_LOAD: begin
        if (host_total >= llha_pkg::MAX_HOSTS) begin
          rep.status = llha_pkg::STAT_FULL;
        end else begin
          host_total = host_total + 1;
          load_mem[host_total] = hload;
          id_mem[host_total]   = hid;
          heap_built = 1'b0;
        end
      end
      llha_pkg::FUNC_ALLOC: begin
        alloc_seq = alloc_seq + 1'b1;
        rep.job_number = alloc_seq;
        if (host_total == 0) begin
          rep.status = llha_pkg::STAT_NOHOST;
        end else begin
          if (!heap_built) begin
            for (int p = host_total / 2; p >= 1; p--) sink_host(p, host_total);
            heap_built = 1'b1;
          end
          sum = int'(load_mem[1]) + int'(job);
          if (sum <= int'(cap_reg)) begin
            rep.host      = id_mem[1];
            rep.prev_load = load_mem[1];
            rep.new_load  = sum[llha_pkg::LOAD_W-1:0];
            load_mem[1]   = sum[llha_pkg::LOAD_W-1:0];
            sink_host(1, host_total);
          end else begin
            rep.status = llha_pkg::STAT_REJECT;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic check_field(string what, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t checker: %s mismatch, expected %0h got %0h", $time, what, exp_v, got_v);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      host_total = 0;
      heap_built = 1'b0;
      alloc_seq  = '0;
      cap_reg    = llha_pkg::CAP_RESET;
      report_q.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall)
        report_q.push_back(compute_report(in_func, in_host_id, in_host_load, in_job_load));
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $display("%0t checker: result item with nothing expected, status %0d host %0h",
                   $time, out_status, out_placed_host);
          errors = errors + 1;
        end else begin
          want = report_q.pop_front();
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("placed_host", want.host, out_placed_host);
          check_field("prev_load", 16'(want.prev_load), 16'(out_prev_load));
          check_field("new_load", 16'(want.new_load), 16'(out_new_load));
          check_field("job_number", want.job_number, out_job_number);
        end
      end
      // register write lands at this edge, after any item taken here
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        cap_reg = pwdata[llha_pkg::LOAD_W-1:0];
      outstanding <= report_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least loaded host allocator testbench
// directed corner items, then random clear/load/allocate sequences with
// capacity changes between phases; random idles and stalls on both sides
// ----------------------------------------------------------------------------
module tb;

  localparam logic [llha_pkg::FUNC_W-1:0]     FUNC_UNUSED = 2'd3;
  localparam logic [llha_pkg::CFG_ADDR_W-1:0] CAP_ADDR    = {llha_pkg::REG_CAPACITY, 2'b00};
  localparam int                              ITEM_TARGET = 1250;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [llha_pkg::FUNC_W-1:0]     in_func = '0;
  logic [llha_pkg::ID_W-1:0]       in_host_id = '0;
  logic [llha_pkg::LOAD_W-1:0]     in_host_load = '0;
  logic [llha_pkg::LOAD_W-1:0]     in_job_load = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [llha_pkg::STATUS_W-1:0]   out_status;
  logic [llha_pkg::ID_W-1:0]       out_placed_host;
  logic [llha_pkg::LOAD_W-1:0]     out_prev_load;
  logic [llha_pkg::LOAD_W-1:0]     out_new_load;
  logic [llha_pkg::JOB_W-1:0]      out_job_number;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [llha_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [llha_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [llha_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int outstanding;
  int errors;
  int n_items, n_loads, n_allocs, n_other, n_cap_writes;
  bit quiet;

  always #5 clk = ~clk;

  least_loaded_host_allocator_unit u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_host_id, .in_host_load, .in_job_load,
    .out_valid, .out_stall, .out_status, .out_placed_host, .out_prev_load,
    .out_new_load, .out_job_number,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  llha_alloc_checker u_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_host_id, .in_host_load, .in_job_load,
    .out_valid, .out_stall, .out_status, .out_placed_host, .out_prev_load,
    .out_new_load, .out_job_number,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .outstanding, .errors
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 21);
    end
  end

  task automatic send_item(logic [llha_pkg::FUNC_W-1:0] func,
                           logic [llha_pkg::ID_W-1:0] hid,
                           logic [llha_pkg::LOAD_W-1:0] hload,
                           logic [llha_pkg::LOAD_W-1:0] job);
    quiet = (n_items >= 500 && n_items < 700);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_host_id   <= hid;
    in_host_load <= hload;
    in_job_load  <= job;
    do @(posedge clk); while (in_stall);
    n_items = n_items + 1;
    case (func)
      llha_pkg::FUNC_LOAD:  n_loads = n_loads + 1;
      llha_pkg::FUNC_ALLOC: n_allocs = n_allocs + 1;
      default:              n_other = n_other + 1;
    endcase
  endtask

  // hold off the sender until every result item is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [llha_pkg::LOAD_W-1:0] cap);
    drain();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {24'($urandom), cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_cap_writes = n_cap_writes + 1;
  endtask

  function automatic logic [llha_pkg::LOAD_W-1:0] pick_load(int narrow_pct, int narrow_max);
    if ($urandom_range(99) < narrow_pct)
      return llha_pkg::LOAD_W'($urandom_range(narrow_max));
    return llha_pkg::LOAD_W'($urandom_range(255));
  endfunction

  initial begin
    int k, m;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unused code, clear restarting the job count
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd7);
    send_item(FUNC_UNUSED, '1, '1, '1);
    send_item(llha_pkg::FUNC_CLEAR, '1, '1, '1);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd0);
    // equal loads to exercise tie handling in the heap
    send_item(llha_pkg::FUNC_LOAD, 16'hFFFF, 8'd255, '0);
    send_item(llha_pkg::FUNC_LOAD, 16'h0000, 8'd0, '1);
    send_item(llha_pkg::FUNC_LOAD, 16'h1234, 8'd40, '0);
    send_item(llha_pkg::FUNC_LOAD, 16'hA5A5, 8'd40, '0);
    send_item(llha_pkg::FUNC_LOAD, 16'h5A5A, 8'd40, '0);
    send_item(llha_pkg::FUNC_ALLOC, '1, '1, 8'd0);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd255);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd100);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd40);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd61);
    send_item(llha_pkg::FUNC_LOAD, 16'h0F0F, 8'd1, '0);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd99);
    set_capacity(8'd255);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd255);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd215);
    set_capacity(8'd0);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd0);
    send_item(llha_pkg::FUNC_CLEAR, '0, '0, '0);
    send_item(llha_pkg::FUNC_LOAD, 16'h0007, 8'd0, '0);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd0);
    send_item(llha_pkg::FUNC_ALLOC, '0, '0, 8'd1);
    set_capacity(llha_pkg::CAP_RESET);

    // first random phase fills the table past its limit
    k = llha_pkg::MAX_HOSTS + 3;
    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(4))
          0:       set_capacity(8'd0);
          1:       set_capacity(8'd255);
          2:       set_capacity(llha_pkg::CAP_RESET);
          default: set_capacity(llha_pkg::LOAD_W'($urandom_range(255)));
        endcase
      end
      if ($urandom_range(99) < 70)
        send_item(llha_pkg::FUNC_CLEAR, llha_pkg::ID_W'($urandom), '0, '0);
      repeat (k) begin
        send_item(llha_pkg::FUNC_LOAD, llha_pkg::ID_W'($urandom), pick_load(75, 15),
                  llha_pkg::LOAD_W'($urandom));
      end
      m = $urandom_range(3, 20);
      repeat (m) begin
        case ($urandom_range(19))
          0:       send_item(FUNC_UNUSED, llha_pkg::ID_W'($urandom),
                             llha_pkg::LOAD_W'($urandom), llha_pkg::LOAD_W'($urandom));
          1:       send_item(llha_pkg::FUNC_CLEAR, llha_pkg::ID_W'($urandom),
                             llha_pkg::LOAD_W'($urandom), '0);
          2, 3:    send_item(llha_pkg::FUNC_LOAD, llha_pkg::ID_W'($urandom),
                             pick_load(75, 15), '0);
          default: send_item(llha_pkg::FUNC_ALLOC, llha_pkg::ID_W'($urandom),
                             llha_pkg::LOAD_W'($urandom), pick_load(70, 20));
        endcase
      end
      k = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 12);
    end

    drain();
    repeat (40) @(posedge clk);
    $display("run: %0d items (%0d host loads, %0d allocations, %0d clear/unused)",
             n_items, n_loads, n_allocs, n_other);
    $display("run: %0d capacity writes incl. 0 and 255, table overflow, idle-free window",
             n_cap_writes);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb: FAIL");
    $finish;
  end

endmodule
